// ===== rtl/raster_draw_engine_assert.svh =====
// Assertion macros for the raster draw engine
`ifndef RASTER_DRAW_ENGINE_ASSERT_SVH
`define RASTER_DRAW_ENGINE_ASSERT_SVH

// same-cycle implication
`define RDE_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RDE_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rde_pkg.sv =====
`timescale 1ns / 1ps
package rde_pkg;

  // fixed point and divider widths
  localparam int QB    = 16;
  localparam int ACC_W = 30;
  localparam int DIV_W = 29;
  localparam int MAG_W = 28;
  localparam int DEN_W = 12;

  // command codes
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PIXEL = 3'd1;
  localparam logic [2:0] OP_LINE  = 3'd2;
  localparam logic [2:0] OP_TRI   = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/rde_div.sv =====
`timescale 1ns / 1ps
module rde_div (
  input  logic              clk,
  input  logic              rst,
  input  rde_pkg::div_req_t req,
  output rde_pkg::div_rsp_t rsp
);
  import rde_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] mag;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic             neg;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [MAG_W-1:0] num_mag;
  logic [DEN_W:0]   trial_sub;

  // one restoring step: shift in the next numerator bit, try the divisor
  always_comb begin
    trial     = {rem, mag[MAG_W-1]};
    fits      = trial >= {1'b0, den};
    trial_sub = trial - {1'b0, den};
    num_mag   = req.num[DIV_W-1] ? MAG_W'(-req.num) : MAG_W'(req.num);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W - 1);
        mag  <= num_mag;
        rem  <= '0;
        den  <= req.den;
        neg  <= req.num[DIV_W-1];
      end else if (busy) begin
        rem <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        mag <= {mag[MAG_W-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // truncating quotient, sign restored
  always_comb begin
    rsp.done = done;
    rsp.quo  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

// ===== rtl/raster_draw_engine.sv =====
`timescale 1ns / 1ps
// Raster draw engine: a FRAME_WIDTH x FRAME_HEIGHT store of 32-bit colors
// driven by one command word per input handshake (in_valid / in_ready).
// Commands: clear, pixel write, DDA line, triangle fill, pixel read.
// Coordinates are centered; pixels that fall outside the frame are dropped.
// Every command returns one result word on out_valid / out_ready:
// read_value and inside_res carry the read answer, zero for other commands.
// in_ready is high only while the engine is idle; one command at a time.
// Cost per command is set by the one-pixel-per-cycle write port and the
// shared 28-step divider: a clear writes every word of the frame, a line
// uses two divisions and then writes length + 1 points, and a triangle
// uses three divisions with a flat edge and five when split, then fills
// each row's drawn span.
// A finished result sits in the output register; the next command is taken
// meanwhile, and its own result waits until the receiver takes the first.
// Reset (rst, synchronous) returns to idle with no result pending; the
// frame store is not cleared and reads undefined until written.
module raster_draw_engine #(
  parameter int FRAME_WIDTH  = 128,
  parameter int FRAME_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic signed [11:0] ax,
  input  logic signed [11:0] ay,
  input  logic signed [11:0] bx,
  input  logic signed [11:0] by,
  input  logic signed [11:0] cx,
  input  logic signed [11:0] cy,
  input  logic [31:0]        paint,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        read_value,
  output logic               inside_res
);
  import rde_pkg::*;
  `include "raster_draw_engine_assert.svh"

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [13:0] XMIN = 14'(-(FRAME_WIDTH / 2));
  localparam logic signed [13:0] XMAX = 14'(FRAME_WIDTH - FRAME_WIDTH / 2 - 1);

  localparam logic [2:0] DV_LX = 3'd0;
  localparam logic [2:0] DV_LY = 3'd1;
  localparam logic [2:0] DV_MX = 3'd2;
  localparam logic [2:0] DV_S1 = 3'd3;
  localparam logic [2:0] DV_S2 = 3'd4;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CLEAR = 15'b000000000000010,
    S_PIXEL = 15'b000000000000100,
    S_LSET  = 15'b000000000001000,
    S_WALK  = 15'b000000000010000,
    S_SORT  = 15'b000000000100000,
    S_TCHK  = 15'b000000001000000,
    S_MXL   = 15'b000000010000000,
    S_DIVW  = 15'b000000100000000,
    S_ROW   = 15'b000001000000000,
    S_SPAN  = 15'b000010000000000,
    S_NEXT  = 15'b000100000000000,
    S_READ  = 15'b001000000000000,
    S_RDW   = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  state_t state;

  // command registers
  logic [2:0]         op;
  logic [31:0]        color;
  logic signed [11:0] x0, y0, x1, y1, x2, y2, mx;
  logic [11:0]        len;
  logic               half;
  logic [2:0]         div_sel;

  // walk registers
  logic signed [DIV_W-1:0] step_x, step_y;
  logic signed [ACC_W-1:0] span_left, span_right;
  logic [12:0]             step_left;
  logic signed [11:0]      row_now;
  logic signed [13:0]      col, col_hi;
  logic signed [25:0]      prod;
  logic [AW-1:0]           clr_addr;

  // result
  logic        res_in;
  logic [31:0] res_val;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // frame store
  logic [31:0] mem [DEPTH];
  logic [31:0] rd_q;
  logic        mem_we;
  logic        mem_re;
  logic [AW-1:0] mem_wa;

  // differences feeding the divider
  logic signed [12:0] dx_ab, dy_ab, d_mx0, d_21, d_2mx, dy_21, dy_20, dx_20;
  logic [11:0]        adx, ady, len_c;

  // sorted vertices
  logic signed [11:0] sx0, sy0, sx1, sy1, sx2, sy2, tx, ty;

  // pixel address path
  logic signed [14:0] wx, wy;
  logic [15:0]        pxs, pys, rys;
  logic               pix_in, row_in;
  logic [AW-1:0]      pix_addr;

  // span setup
  logic signed [13:0] tl, tr, lo, hi, lo_c, hi_c;

  rde_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  function automatic logic signed [DIV_W-1:0] q_num(input logic signed [12:0] d);
    q_num = {d, 16'b0};
  endfunction

  function automatic logic signed [ACC_W-1:0] q_pos(input logic signed [11:0] v);
    q_pos = {{2{v[11]}}, v, 16'b0};
  endfunction

  function automatic logic signed [ACC_W-1:0] q_step(input logic signed [DIV_W-1:0] v);
    q_step = {v[DIV_W-1], v};
  endfunction

  // Q16 to integer, truncated toward zero
  function automatic logic signed [13:0] trunc_q(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + (v[ACC_W-1] ? ACC_W'(2**QB - 1) : ACC_W'(0));
    trunc_q = t[ACC_W-1:QB];
  endfunction

  // Q16 to integer, half away from zero
  function automatic logic signed [14:0] round_q(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] r;
    logic [14:0]      rr;
    m  = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    r  = m + ACC_W'(2**(QB - 1));
    rr = {1'b0, r[ACC_W-1:QB]};
    round_q = v[ACC_W-1] ? -$signed(rr) : $signed(rr);
  endfunction

  // edge differences
  always_comb begin
    dx_ab = {x1[11], x1} - {x0[11], x0};
    dy_ab = {y1[11], y1} - {y0[11], y0};
    d_mx0 = {mx[11], mx} - {x0[11], x0};
    d_21  = {x2[11], x2} - {x1[11], x1};
    d_2mx = {x2[11], x2} - {mx[11], mx};
    dy_21 = {y2[11], y2} - {y1[11], y1};
    dy_20 = {y2[11], y2} - {y0[11], y0};
    dx_20 = {x2[11], x2} - {x0[11], x0};
    adx   = dx_ab[12] ? 12'(-dx_ab) : dx_ab[11:0];
    ady   = dy_ab[12] ? 12'(-dy_ab) : dy_ab[11:0];
    len_c = (adx >= ady) ? adx : ady;
  end

  // three compare-swaps on y
  always_comb begin
    sx0 = x0; sy0 = y0; sx1 = x1; sy1 = y1; sx2 = x2; sy2 = y2;
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
    if (sy1 > sy2) begin
      tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
    end
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
    tx = '0;
    ty = '0;
  end

  // pixel coordinate and frame address
  always_comb begin
    wx = {{3{x0[11]}}, x0};
    wy = {{3{y0[11]}}, y0};
    if (state == S_WALK) begin
      wx = round_q(span_left);
      wy = round_q(span_right);
    end else if (state == S_SPAN) begin
      wx = {col[13], col};
      wy = {{3{row_now[11]}}, row_now};
    end
    pxs      = {wx[14], wx} + 16'(FRAME_WIDTH / 2);
    pys      = {wy[14], wy} + 16'(FRAME_HEIGHT / 2);
    pix_in   = !pxs[15] && (pxs < 16'(FRAME_WIDTH)) &&
               !pys[15] && (pys < 16'(FRAME_HEIGHT));
    pix_addr = AW'(pys) * AW'(FRAME_WIDTH) + AW'(pxs);
    mem_we   = (state == S_CLEAR) ||
               (((state == S_PIXEL) || (state == S_WALK) || (state == S_SPAN)) && pix_in);
    mem_re   = (state == S_READ) && pix_in;
    mem_wa   = (state == S_CLEAR) ? clr_addr : pix_addr;
  end

  // span ends for the current row, clipped to the frame
  always_comb begin
    tl     = trunc_q(span_left);
    tr     = trunc_q(span_right);
    lo     = (tl < tr) ? tl : tr;
    hi     = (tl < tr) ? tr : tl;
    lo_c   = (lo < XMIN) ? XMIN : lo;
    hi_c   = (hi > XMAX) ? XMAX : hi;
    rys    = {{4{row_now[11]}}, row_now} + 16'(FRAME_HEIGHT / 2);
    row_in = !rys[15] && (rys < 16'(FRAME_HEIGHT));
  end

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= color;
    end
    if (mem_re) begin
      rd_q <= mem[pix_addr];
    end
  end

  assign in_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      // S_FIN refills the output register itself
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op      <= operation;
            color   <= paint;
            x0      <= ax; y0 <= ay;
            x1      <= bx; y1 <= by;
            x2      <= cx; y2 <= cy;
            res_in  <= 1'b0;
            res_val <= '0;
            clr_addr <= '0;
            case (operation)
              OP_CLEAR: state <= S_CLEAR;
              OP_PIXEL: state <= S_PIXEL;
              OP_LINE:  state <= S_LSET;
              OP_TRI:   state <= S_SORT;
              OP_READ:  state <= S_READ;
              default:  state <= S_FIN;
            endcase
          end
        end
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_FIN;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_PIXEL: state <= S_FIN;
        S_LSET: begin
          len <= len_c;
          if (len_c == '0) begin
            state <= S_PIXEL;
          end else begin
            div_req.start <= 1'b1;
            div_req.num   <= q_num(dx_ab);
            div_req.den   <= len_c;
            div_sel       <= DV_LX;
            state         <= S_DIVW;
          end
        end
        S_WALK: begin
          span_left  <= span_left + q_step(step_x);
          span_right <= span_right + q_step(step_y);
          step_left  <= step_left - 1'b1;
          if (step_left == 13'd1) begin
            state <= S_FIN;
          end
        end
        S_SORT: begin
          x0 <= sx0; y0 <= sy0;
          x1 <= sx1; y1 <= sy1;
          x2 <= sx2; y2 <= sy2;
          state <= S_TCHK;
        end
        S_TCHK: begin
          prod <= 26'(dx_20) * 26'(dy_ab);
          if (y0 == y2) begin
            state <= S_PIXEL;
          end else begin
            state <= S_MXL;
          end
        end
        S_MXL: begin
          div_req.start <= 1'b1;
          div_req.num   <= {{3{prod[25]}}, prod};
          div_req.den   <= dy_20[11:0];
          div_sel       <= DV_MX;
          state         <= S_DIVW;
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            case (div_sel)
              DV_LX: begin
                step_x        <= div_rsp.quo;
                div_req.start <= 1'b1;
                div_req.num   <= q_num(dy_ab);
                div_req.den   <= len;
                div_sel       <= DV_LY;
              end
              DV_LY: begin
                step_y     <= div_rsp.quo;
                span_left  <= q_pos(x0);
                span_right <= q_pos(y0);
                step_left  <= {1'b0, len} + 13'd1;
                state      <= S_WALK;
              end
              DV_MX: begin
                mx            <= x0 + div_rsp.quo[11:0];
                div_req.start <= 1'b1;
                div_sel       <= DV_S1;
                if (y1 > y0) begin
                  half        <= 1'b0;
                  div_req.num <= q_num(dx_ab);
                  div_req.den <= dy_ab[11:0];
                end else begin
                  half        <= 1'b1;
                  div_req.num <= q_num(d_21);
                  div_req.den <= dy_21[11:0];
                end
              end
              DV_S1: begin
                step_x        <= div_rsp.quo;
                div_req.start <= 1'b1;
                div_sel       <= DV_S2;
                div_req.num   <= half ? q_num(d_2mx) : q_num(d_mx0);
                div_req.den   <= half ? dy_21[11:0] : dy_ab[11:0];
              end
              DV_S2: begin
                step_y     <= div_rsp.quo;
                span_left  <= half ? q_pos(x2) : q_pos(x0);
                span_right <= half ? q_pos(x2) : q_pos(x0);
                row_now    <= half ? y2 : y0;
                state      <= S_ROW;
              end
              default: state <= S_FIN;
            endcase
          end else begin
            // start is a one-cycle pulse
            div_req.start <= 1'b0;
          end
        end
        S_ROW: begin
          col    <= lo_c;
          col_hi <= hi_c;
          if (row_in && (lo_c <= hi_c)) begin
            state <= S_SPAN;
          end else begin
            state <= S_NEXT;
          end
        end
        S_SPAN: begin
          if (col == col_hi) begin
            state <= S_NEXT;
          end else begin
            col <= col + 1'b1;
          end
        end
        S_NEXT: begin
          if (row_now == y1) begin
            if (!half && (y2 != y1)) begin
              half          <= 1'b1;
              div_req.start <= 1'b1;
              div_req.num   <= q_num(d_21);
              div_req.den   <= dy_21[11:0];
              div_sel       <= DV_S1;
              state         <= S_DIVW;
            end else begin
              state <= S_FIN;
            end
          end else if (half) begin
            row_now    <= row_now - 1'b1;
            span_left  <= span_left - q_step(step_x);
            span_right <= span_right - q_step(step_y);
            state      <= S_ROW;
          end else begin
            row_now    <= row_now + 1'b1;
            span_left  <= span_left + q_step(step_x);
            span_right <= span_right + q_step(step_y);
            state      <= S_ROW;
          end
        end
        S_READ: begin
          res_in <= pix_in;
          state  <= S_RDW;
        end
        S_RDW: begin
          res_val <= res_in ? rd_q : 32'd0;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            read_value <= (op == OP_READ) ? res_val : 32'd0;
            inside_res <= (op == OP_READ) ? res_in : 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `RDE_ASSERT_NOW(a_we_state, clk, rst, mem_we, (state == S_CLEAR) || (state == S_PIXEL) || (state == S_WALK) || (state == S_SPAN), "frame write outside a drawing state")
  `RDE_ASSERT_NOW(a_zero_out, clk, rst, out_valid && !inside_res, read_value == 32'd0, "nonzero value for a word outside the frame")
  `RDE_ASSERT_NXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "engine took a word while still busy")
  `RDE_ASSERT_NOW(a_div_wait, clk, rst, div_rsp.done, state == S_DIVW, "divider finished with nobody waiting")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import rde_pkg::*;

  localparam int FW = 128;
  localparam int FH = 128;
  localparam int RAND_WORDS = 1400;
  localparam int HOLD_CYCLES = 400;
  // codes outside the command set: the engine draws nothing but still returns a zero result word
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic signed [11:0] ax, ay, bx, by, cx, cy;
    logic [31:0]        paint;
    bit                 fixed;
    logic [31:0]        fvalue;
    logic               finside;
  } cmd_t;

  typedef struct {
    logic [31:0] value;
    logic        in_frame;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] operation = '0;
  logic signed [11:0] ax = '0, ay = '0, bx = '0, by = '0, cx = '0, cy = '0;
  logic [31:0] paint = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [31:0] read_value;
  logic inside_res;

  raster_draw_engine #(.FRAME_WIDTH(FW), .FRAME_HEIGHT(FH)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
    .paint(paint), .out_valid(out_valid), .out_ready(out_ready),
    .read_value(read_value), .inside_res(inside_res)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // shadow frame and expected answers
  logic [31:0] shadow_frame [FW*FH];
  answer_t answer_q[$];
  cmd_t cur_cmd;
  cmd_t dir_rows[$];
  int accepted = 0;
  int errors = 0;
  bit hold_armed = 0;

  function automatic void plot(longint x, longint y, logic [31:0] c);
    longint px, py;
    px = x + FW / 2;
    py = y + FH / 2;
    if (px >= 0 && px < FW && py >= 0 && py < FH) shadow_frame[py * FW + px] = c;
  endfunction

  function automatic longint round_half(longint v);
    if (v >= 0) return (v + 32768) / 65536;
    return -((-v + 32768) / 65536);
  endfunction

  function automatic void trace_line(longint x0, longint y0, longint x1, longint y1,
                                     logic [31:0] c);
    longint dx, dy, len, sx, sy, px, py;
    dx = x1 - x0;
    dy = y1 - y0;
    len = ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) ? (dx < 0 ? -dx : dx)
                                                         : (dy < 0 ? -dy : dy);
    if (len == 0) begin
      plot(x0, y0, c);
      return;
    end
    sx = dx * 65536 / len;
    sy = dy * 65536 / len;
    px = x0 * 65536;
    py = y0 * 65536;
    for (longint i = 0; i <= len; i++) begin
      plot(round_half(px), round_half(py), c);
      px += sx;
      py += sy;
    end
  endfunction

  function automatic void fill_row(longint row, longint xa, longint xb, logic [31:0] c);
    longint lo, hi;
    lo = xa < xb ? xa : xb;
    hi = xa < xb ? xb : xa;
    if (row + FH / 2 < 0 || row + FH / 2 >= FH) return;
    if (lo < -(FW / 2)) lo = -(FW / 2);
    if (hi > FW - FW / 2 - 1) hi = FW - FW / 2 - 1;
    for (longint x = lo; x <= hi; x++) plot(x, row, c);
  endfunction

  // apex on top, flat edge below
  function automatic void fill_flat_low(longint x0, longint y0, longint x1, longint y1,
                                        longint x2, longint y2, logic [31:0] c);
    longint s1, s2, l, r;
    s1 = (x1 - x0) * 65536 / (y1 - y0);
    s2 = (x2 - x0) * 65536 / (y2 - y0);
    l = x0 * 65536;
    r = x0 * 65536;
    for (longint row = y0; row <= y2; row++) begin
      fill_row(row, l / 65536, r / 65536, c);
      l += s1;
      r += s2;
    end
  endfunction

  // flat edge on top, apex below; walks upward from the apex
  function automatic void fill_flat_high(longint x0, longint y0, longint x1, longint y1,
                                         longint x2, longint y2, logic [31:0] c);
    longint s1, s2, l, r;
    s1 = (x2 - x0) * 65536 / (y2 - y0);
    s2 = (x2 - x1) * 65536 / (y2 - y1);
    l = x2 * 65536;
    r = x2 * 65536;
    for (longint row = y2; row >= y0; row--) begin
      fill_row(row, l / 65536, r / 65536, c);
      l -= s1;
      r -= s2;
    end
  endfunction

  function automatic void fill_tri(longint x0, longint y0, longint x1, longint y1,
                                   longint x2, longint y2, logic [31:0] c);
    longint t, mx;
    if (y0 > y1) begin t = y0; y0 = y1; y1 = t; t = x0; x0 = x1; x1 = t; end
    if (y1 > y2) begin t = y1; y1 = y2; y2 = t; t = x1; x1 = x2; x2 = t; end
    if (y0 > y1) begin t = y0; y0 = y1; y1 = t; t = x0; x0 = x1; x1 = t; end
    if (y0 == y2) plot(x0, y0, c);
    else if (y1 == y2) fill_flat_low(x0, y0, x1, y1, x2, y2, c);
    else if (y0 == y1) fill_flat_high(x0, y0, x1, y1, x2, y2, c);
    else begin
      mx = (x2 - x0) * (y1 - y0) / (y2 - y0) + x0;
      fill_flat_low(x0, y0, x1, y1, mx, y1, c);
      fill_flat_high(x1, y1, mx, y1, x2, y2, c);
    end
  endfunction

  function automatic answer_t run_cmd(cmd_t c);
    answer_t a;
    longint px, py;
    a.value = '0;
    a.in_frame = 0;
    case (c.op)
      OP_CLEAR: foreach (shadow_frame[i]) shadow_frame[i] = c.paint;
      OP_PIXEL: plot(c.ax, c.ay, c.paint);
      OP_LINE:  trace_line(c.ax, c.ay, c.bx, c.by, c.paint);
      OP_TRI:   fill_tri(c.ax, c.ay, c.bx, c.by, c.cx, c.cy, c.paint);
      OP_READ: begin
        px = longint'(c.ax) + FW / 2;
        py = longint'(c.ay) + FH / 2;
        if (px >= 0 && px < FW && py >= 0 && py < FH) begin
          a.value = shadow_frame[py * FW + px];
          a.in_frame = 1;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // accepted command word: update the shadow frame, queue its answer
  always @(posedge clk) begin
    answer_t a;
    if (!rst && in_valid && in_ready) begin
      a = run_cmd(cur_cmd);
      if (cur_cmd.fixed) begin
        a.value = cur_cmd.fvalue;
        a.in_frame = cur_cmd.finside;
      end
      answer_q.push_back(a);
      accepted <= accepted + 1;
    end
  end

  // result word check
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h %b", read_value, inside_res);
      end else begin
        e = answer_q.pop_front();
        if (read_value !== e.value || inside_res !== e.in_frame) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: expected %h/%b, got %h/%b",
                     e.value, e.in_frame, read_value, inside_res);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly small coordinates near the frame, some wider, a few full range
  function automatic logic signed [11:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 12'(int'($urandom_range(0, 150)) - 75);
    if (r < 95) return 12'(int'($urandom_range(0, 600)) - 300);
    return 12'($urandom);
  endfunction

  function automatic cmd_t pick_cmd();
    cmd_t c;
    int r;
    r = $urandom_range(0, 999);
    if (r < 3) c.op = OP_CLEAR;
    else if (r < 200) c.op = OP_PIXEL;
    else if (r < 400) c.op = OP_LINE;
    else if (r < 560) c.op = OP_TRI;
    else if (r < 970) c.op = OP_READ;
    else c.op = 3'($urandom_range(5, 7));
    c.ax = pick_coord(); c.ay = pick_coord();
    c.bx = pick_coord(); c.by = pick_coord();
    c.cx = pick_coord(); c.cy = pick_coord();
    c.paint = $urandom;
    c.fixed = 0;
    c.fvalue = '0;
    c.finside = 0;
    return c;
  endfunction

  function automatic void add_row(logic [2:0] op, int x0, int y0, int x1, int y1,
                                  int x2, int y2, logic [31:0] p, bit fx,
                                  logic [31:0] v, logic ins);
    cmd_t c;
    c.op = op;
    c.ax = 12'(x0); c.ay = 12'(y0); c.bx = 12'(x1); c.by = 12'(y1);
    c.cx = 12'(x2); c.cy = 12'(y2);
    c.paint = p;
    c.fixed = fx;
    c.fvalue = v;
    c.finside = ins;
    dir_rows.push_back(c);
  endfunction

  task automatic send_word(cmd_t c);
    int n;
    n = pick_gap();
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    cur_cmd = c;
    operation <= c.op;
    ax <= c.ax; ay <= c.ay; bx <= c.bx; by <= c.by; cx <= c.cx; cy <= c.cy;
    paint <= c.paint;
    in_valid <= 1;
    n = accepted;
    @(negedge clk);
    while (accepted == n) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(negedge clk);
    while (answer_q.size() != 0) @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_armed) begin
        hold_armed = 0;
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 99) < 75) begin
        out_ready <= 1;
        @(negedge clk);
      end else begin
        out_ready <= 0;
        repeat (pick_gap() + 1) @(negedge clk);
      end
    end
  end

  initial begin
    // directed table: fixed answers where obvious, predictor elsewhere
    add_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 32'hAAAA5555, 1, '0, 0);
    add_row(OP_READ, -64, -64, 0, 0, 0, 0, '0, 1, 32'hAAAA5555, 1);
    add_row(OP_READ, 63, 63, 0, 0, 0, 0, '1, 1, 32'hAAAA5555, 1);
    add_row(OP_READ, 64, 0, 0, 0, 0, 0, '0, 1, '0, 0);
    add_row(OP_READ, -2048, 2047, 0, 0, 0, 0, '0, 1, '0, 0);
    add_row(OP_PIXEL, -64, 63, 0, 0, 0, 0, 32'hFFFFFFFF, 1, '0, 0);
    add_row(OP_READ, -64, 63, 0, 0, 0, 0, '0, 1, 32'hFFFFFFFF, 1);
    add_row(OP_PIXEL, 2047, -2048, 0, 0, 0, 0, 32'h0, 1, '0, 0);
    add_row(OP_LINE, 5, 5, 5, 5, 0, 0, 32'h12345678, 1, '0, 0);
    add_row(OP_READ, 5, 5, 0, 0, 0, 0, '0, 1, 32'h12345678, 1);
    add_row(OP_LINE, -2048, -2048, 2047, 2047, 0, 0, 32'h00FF00FF, 0, '0, 0);
    add_row(OP_LINE, 10, -40, -3, 50, 0, 0, 32'h0F0F0F0F, 0, '0, 0);
    add_row(OP_READ, 0, 0, 0, 0, 0, 0, '0, 0, '0, 0);
    add_row(OP_TRI, 7, 9, 7, 9, 7, 9, 32'hCAFEF00D, 1, '0, 0);
    add_row(OP_READ, 7, 9, 0, 0, 0, 0, '0, 1, 32'hCAFEF00D, 1);
    add_row(OP_TRI, -20, 3, 0, -30, 25, 3, 32'h11111111, 0, '0, 0);
    add_row(OP_TRI, -20, -10, 30, -10, 4, 40, 32'h22222222, 0, '0, 0);
    add_row(OP_TRI, -50, -60, 60, 10, -5, 55, 32'h33333333, 0, '0, 0);
    add_row(OP_TRI, -2048, -2048, 2047, 0, -100, 2047, 32'h44444444, 0, '0, 0);
    add_row(OP_READ, -1, 2, 0, 0, 0, 0, '0, 0, '0, 0);
    add_row(OP_RSVD5, 1, 1, 1, 1, 1, 1, '1, 1, '0, 0);
    add_row(OP_RSVD6, -1, -1, -1, -1, -1, -1, '1, 1, '0, 0);
    add_row(OP_RSVD7, 0, 0, 0, 0, 0, 0, '1, 1, '0, 0);

    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i]);
    wait_drained();

    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == 300) hold_armed = 1;
      if (i == 700) wait_drained();
      send_word(pick_cmd());
    end
    wait_drained();
    repeat (50) @(negedge clk);

    if (errors == 0 && answer_q.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rde_pkg.sv
rtl/rde_div.sv
rtl/raster_draw_engine.sv
tb/tb.sv
